### sv/tbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_pkg
// Shared types and constants for the triangle barycentric weight block.
// ----------------------------------------------------------------------------
package tbw_pkg;

  localparam int COORD_W  = 17;
  localparam int PIX_W    = 12;
  localparam int WEIGHT_W = 32;
  localparam int NUM_W    = 3;
  localparam int IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_VERTEX_A_X = 3'd0,
    REG_VERTEX_A_Y = 3'd1,
    REG_VERTEX_B_X = 3'd2,
    REG_VERTEX_B_Y = 3'd3,
    REG_VERTEX_C_X = 3'd4,
    REG_VERTEX_C_Y = 3'd5
  } cfg_reg_t;

endpackage

### sv/tbw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_in_if
// Pixel position channel: valid/ready handshake with the pixel word.
// ----------------------------------------------------------------------------
interface tbw_in_if
  import tbw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### sv/tbw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_out_if
// Weight channel: valid/ready handshake with the three weights and flags.
// ----------------------------------------------------------------------------
interface tbw_out_if
  import tbw_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight_alpha;
  logic signed [WEIGHT_W-1:0] weight_beta;
  logic signed [WEIGHT_W-1:0] weight_gamma;
  logic [NUM_W-1:0]           degenerate_mask;

  modport source (output valid, output weight_alpha, output weight_beta,
                  output weight_gamma, output degenerate_mask, input ready);
  modport sink   (input valid, input weight_alpha, input weight_beta,
                  input weight_gamma, input degenerate_mask, output ready);
endinterface

### sv/triangle_barycentric_weights_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_weights_top
// Barycentric weights of an integer pixel against a configured triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six vertex coordinates (signed, 1/2^COORD_FRAC_BITS pixel)
//   through cfg_we / cfg_index / cfg_wdata while no word is in flight.
//   Send pixel words on in_ch; each yields one word on out_ch with the
//   alpha, beta and gamma weights (WEIGHT_FRAC_BITS fraction bits, truncated
//   toward zero, saturated to 32 bits) and a degenerate mask for zero
//   denominators (weight then reads 0).
// Timing:
//   The pipeline has two stages of edge products and sums, one divider
//   setup stage, 32 restoring divider stages (one quotient bit each) and an
//   output register. A new pixel is accepted every cycle while out_ch is not stalled.
// Reset:
//   rst_n clears the vertex registers to zero and drops all valid bits.
// Stall:
//   While out_ch holds a word that is not taken the whole pipeline freezes
//   and in_ch.ready goes low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_barycentric_weights_top
  import tbw_pkg::*;
#(
  parameter int COORD_FRAC_BITS  = 4,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  tbw_in_if.sink             in_ch,
  tbw_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_wdata
);

  localparam int PXW = PIX_W + COORD_FRAC_BITS + 1;
  localparam int PW  = COORD_W + 1 + PXW;
  localparam int KW  = 2 * COORD_W;
  localparam int EW  = ((PW > KW) ? PW : KW) + 2;
  localparam int LAT = 2 + 1 + WEIGHT_W + 1;

  logic signed [COORD_W-1:0] vx_r [0:2];
  logic signed [COORD_W-1:0] vy_r [0:2];
  logic signed [COORD_W-1:0] tx [0:2];
  logic signed [COORD_W-1:0] ty [0:2];
  logic [COORD_W-1:0]        fmask;

  logic [LAT-1:0] vld_r;
  logic           ce;

  logic signed [PXW-1:0] px, py;

  logic signed [WEIGHT_W-1:0] w [0:2];
  logic [NUM_W-1:0]           dg;

  assign ce          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = ce;

  // vertex registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A_X: vx_r[0] <= cfg_wdata;
        REG_VERTEX_A_Y: vy_r[0] <= cfg_wdata;
        REG_VERTEX_B_X: vx_r[1] <= cfg_wdata;
        REG_VERTEX_B_Y: vy_r[1] <= cfg_wdata;
        REG_VERTEX_C_X: vx_r[2] <= cfg_wdata;
        REG_VERTEX_C_Y: vy_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // truncate vertices toward zero to whole pixels
  assign fmask = COORD_W'((COORD_W'(1) << COORD_FRAC_BITS) - COORD_W'(1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tx[i] = vx_r[i] & ~fmask;
      ty[i] = vy_r[i] & ~fmask;
      if (vx_r[i][COORD_W-1] && ((vx_r[i] & fmask) != '0)) begin
        tx[i] = tx[i] + COORD_W'(fmask + COORD_W'(1));
      end
      if (vy_r[i][COORD_W-1] && ((vy_r[i] & fmask) != '0)) begin
        ty[i] = ty[i] + COORD_W'(fmask + COORD_W'(1));
      end
    end
  end

  assign px = $signed(PXW'({in_ch.pixel_x, {COORD_FRAC_BITS{1'b0}}}));
  assign py = $signed(PXW'({in_ch.pixel_y, {COORD_FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int I = (e == 0) ? 1 : 0;
    localparam int J = (e == 2) ? 1 : 2;

    logic signed [COORD_W:0] dy, dx;
    logic signed [EW-1:0] p1_r, p2_r, d1_r, d2_r, k_r, m_r;
    logic signed [EW-1:0] num_r, den_r;

    assign dy = $signed({vy_r[I][COORD_W-1], vy_r[I]})
              - $signed({vy_r[J][COORD_W-1], vy_r[J]});
    assign dx = $signed({vx_r[J][COORD_W-1], vx_r[J]})
              - $signed({vx_r[I][COORD_W-1], vx_r[I]});

    // stage 1: products
    always_ff @(posedge clk) begin
      if (ce) begin
        p1_r <= EW'(dy * px);
        p2_r <= EW'(dx * py);
        d1_r <= EW'(dy * tx[e]);
        d2_r <= EW'(dx * ty[e]);
        k_r  <= EW'(vx_r[I] * vy_r[J]);
        m_r  <= EW'(vx_r[J] * vy_r[I]);
      end
    end

    // stage 2: edge function sums
    always_ff @(posedge clk) begin
      if (ce) begin
        num_r <= p1_r + p2_r + k_r - m_r;
        den_r <= d1_r + d2_r + k_r - m_r;
      end
    end

    tbw_div_lane #(
      .EW               (EW),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_div (
      .clk    (clk),
      .ce     (ce),
      .num    (num_r),
      .den    (den_r),
      .weight (w[e]),
      .degen  (dg[e])
    );
  end

  assign out_ch.valid           = vld_r[LAT-1];
  assign out_ch.weight_alpha    = w[0];
  assign out_ch.weight_beta     = w[1];
  assign out_ch.weight_gamma    = w[2];
  assign out_ch.degenerate_mask = dg;

endmodule

### sv/tbw_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_div_lane
// Pipelined signed divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module tbw_div_lane
  import tbw_pkg::*;
#(
  parameter int EW               = 38,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       ce,
  input  logic signed [EW-1:0]       num,
  input  logic signed [EW-1:0]       den,
  output logic signed [WEIGHT_W-1:0] weight,
  output logic                       degen
);

  localparam int NW = EW + WEIGHT_FRAC_BITS;
  localparam int DW = EW + WEIGHT_W;
  localparam int QS = WEIGHT_W;

  logic [EW-1:0]       un, ud;
  logic [NW-1:0]       nshift;
  logic [DW-1:0]       nwide;
  logic [EW-1:0]       hi;

  logic [EW-1:0]       rem_r [0:QS];
  logic [EW-1:0]       ud_r  [0:QS];
  logic [WEIGHT_W-1:0] low_r [0:QS];
  logic [WEIGHT_W-1:0] q_r   [0:QS];
  logic                neg_r [0:QS];
  logic                sat_r [0:QS];
  logic                dz_r  [0:QS];

  logic signed [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                       degen_r;

  always_comb begin
    un     = num[EW-1] ? EW'(-num) : EW'(num);
    ud     = den[EW-1] ? EW'(-den) : EW'(den);
    nshift = {un, {WEIGHT_FRAC_BITS{1'b0}}};
    nwide  = DW'(nshift);
    hi     = nwide[DW-1:WEIGHT_W];
  end

  // quotient >= 2^32 when the top part already reaches the divisor
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= hi;
      ud_r[0]  <= ud;
      low_r[0] <= nwide[WEIGHT_W-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= num[EW-1] ^ den[EW-1];
      sat_r[0] <= (hi >= ud);
      dz_r[0]  <= (den == '0);
    end
  end

  for (genvar k = 0; k < QS; k++) begin : g_step
    logic [EW:0]   t;
    logic          ge;
    logic [EW-1:0] rem_nxt;

    always_comb begin
      t       = {rem_r[k], low_r[k][WEIGHT_W-1]};
      ge      = (t >= {1'b0, ud_r[k]});
      rem_nxt = ge ? EW'(t - {1'b0, ud_r[k]}) : t[EW-1:0];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k+1] <= rem_nxt;
        ud_r[k+1]  <= ud_r[k];
        low_r[k+1] <= {low_r[k][WEIGHT_W-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][WEIGHT_W-2:0], ge};
        neg_r[k+1] <= neg_r[k];
        sat_r[k+1] <= sat_r[k];
        dz_r[k+1]  <= dz_r[k];
      end
    end
  end

  always_comb begin
    if (dz_r[QS]) begin
      weight_nxt = '0;
    end else if (neg_r[QS]) begin
      if (sat_r[QS] || q_r[QS][WEIGHT_W-1]) begin
        weight_nxt = {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
        weight_nxt = -$signed(q_r[QS]);
      end
    end else begin
      if (sat_r[QS] || q_r[QS][WEIGHT_W-1]) begin
        weight_nxt = {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
        weight_nxt = $signed(q_r[QS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      weight_r <= weight_nxt;
      degen_r  <= dz_r[QS];
    end
  end

  assign weight = weight_r;
  assign degen  = degen_r;

endmodule
